[rtl/mdc_pkg.sv]
// Shared types, codes and direction tables for the maze carver.
package mdc_pkg;

    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;
    localparam int COORD_W  = 6;
    localparam int ORDER_W  = 5;
    localparam int TRY_W    = 3;
    localparam int EPOCH_W  = 8;
    localparam int ORDER_MAX = 23;
    localparam int ORDERS    = 24;
    localparam int DIRS      = 4;

    localparam logic [1:0] REG_GRID_WIDTH   = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_START_COLUMN = 2'd2;
    localparam logic [1:0] REG_START_ROW    = 2'd3;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    localparam logic [1:0] EV_START = 2'd0;
    localparam logic [1:0] EV_CARVE = 2'd1;
    localparam logic [1:0] EV_BACK  = 2'd2;
    localparam logic [1:0] EV_IDLE  = 2'd3;

    typedef struct packed {
        logic [6:0] grid_width;
        logic [6:0] grid_height;
        logic [5:0] start_column;
        logic [5:0] start_row;
    } t_cfg;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [1:0]         side;
        logic [1:0]         kind;
        logic               fin;
    } t_result;

    // lexicographic permutations of up, left, right, down
    localparam logic [1:0] PERM_TABLE [ORDERS][DIRS] = '{
        '{DIR_UP,    DIR_LEFT,  DIR_RIGHT, DIR_DOWN },
        '{DIR_UP,    DIR_LEFT,  DIR_DOWN,  DIR_RIGHT},
        '{DIR_UP,    DIR_RIGHT, DIR_LEFT,  DIR_DOWN },
        '{DIR_UP,    DIR_RIGHT, DIR_DOWN,  DIR_LEFT },
        '{DIR_UP,    DIR_DOWN,  DIR_LEFT,  DIR_RIGHT},
        '{DIR_UP,    DIR_DOWN,  DIR_RIGHT, DIR_LEFT },
        '{DIR_LEFT,  DIR_UP,    DIR_RIGHT, DIR_DOWN },
        '{DIR_LEFT,  DIR_UP,    DIR_DOWN,  DIR_RIGHT},
        '{DIR_LEFT,  DIR_RIGHT, DIR_UP,    DIR_DOWN },
        '{DIR_LEFT,  DIR_RIGHT, DIR_DOWN,  DIR_UP   },
        '{DIR_LEFT,  DIR_DOWN,  DIR_UP,    DIR_RIGHT},
        '{DIR_LEFT,  DIR_DOWN,  DIR_RIGHT, DIR_UP   },
        '{DIR_RIGHT, DIR_UP,    DIR_LEFT,  DIR_DOWN },
        '{DIR_RIGHT, DIR_UP,    DIR_DOWN,  DIR_LEFT },
        '{DIR_RIGHT, DIR_LEFT,  DIR_UP,    DIR_DOWN },
        '{DIR_RIGHT, DIR_LEFT,  DIR_DOWN,  DIR_UP   },
        '{DIR_RIGHT, DIR_DOWN,  DIR_UP,    DIR_LEFT },
        '{DIR_RIGHT, DIR_DOWN,  DIR_LEFT,  DIR_UP   },
        '{DIR_DOWN,  DIR_UP,    DIR_LEFT,  DIR_RIGHT},
        '{DIR_DOWN,  DIR_UP,    DIR_RIGHT, DIR_LEFT },
        '{DIR_DOWN,  DIR_LEFT,  DIR_UP,    DIR_RIGHT},
        '{DIR_DOWN,  DIR_LEFT,  DIR_RIGHT, DIR_UP   },
        '{DIR_DOWN,  DIR_RIGHT, DIR_UP,    DIR_LEFT },
        '{DIR_DOWN,  DIR_RIGHT, DIR_LEFT,  DIR_UP   }
    };

    function automatic logic [1:0] perm_dir(input logic [ORDER_W-1:0] order,
                                            input logic [1:0] slot);
        return PERM_TABLE[order][slot];
    endfunction

    function automatic logic [ORDER_W-1:0] clamp_code(input logic [ORDER_W-1:0] code);
        return (code > ORDER_W'(ORDER_MAX)) ? ORDER_W'(ORDER_MAX) : code;
    endfunction

endpackage

[rtl/randomized_dfs_maze_carver.sv]
// Top level of the depth-first maze carver: move sequencer, visited map and path stack.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-----------------------------------------
//  request  | i_in_valid / o_in_stall      | i_begin_new, i_order_code
//  result   | o_out_valid / i_out_stall    | o_cell_column, o_cell_row, o_wall_side,
//           |                              | o_event_kind, o_finished
//  config   | psel, penable, pwrite/pready | paddr, pwdata, prdata
//
// One request at a time. A start marks and pushes the start cell, then emits; a move
// on an empty stack emits an idle result; a move reads the top frame from the stack RAM,
// skips off-grid tries and checks each in-grid neighbour by a registered visited-RAM read.
// Visited cells carry an epoch tag; a clearing pass over all MAX_COLUMNS*MAX_ROWS cells
// runs after reset and before a start once all 255 epochs are spent, with o_in_stall high.
// A stalled result holds the sequencer only when a further result is ready.
module randomized_dfs_maze_carver #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_begin_new,
    input  logic [4:0]                  i_order_code,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [5:0]                  o_cell_column,
    output logic [5:0]                  o_cell_row,
    output logic [1:0]                  o_wall_side,
    output logic [1:0]                  o_event_kind,
    output logic                        o_finished,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mdc_pkg::PADDR_W-1:0] paddr,
    input  logic [mdc_pkg::PDATA_W-1:0] pwdata,
    output logic [mdc_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import mdc_pkg::*;

    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int LW    = $clog2(CELLS + 1);
    localparam int MW    = (CW > RW) ? CW : RW;
    localparam int XW    = ((MW > 7) ? MW : 7) + 1;

    typedef struct packed {
        logic [CW-1:0]      col;
        logic [RW-1:0]      row;
        logic [ORDER_W-1:0] order;
        logic [TRY_W-1:0]   try_idx;
    } t_frame;

    localparam int FW = $bits(t_frame);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_START = 8'b0000_0100,
        S_TOP   = 8'b0000_1000,
        S_PROBE = 8'b0001_0000,
        S_CHECK = 8'b0010_0000,
        S_PUSH  = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } t_state;

    t_cfg cfg;

    t_state             r_state, n_state;
    logic [LW-1:0]      r_level, n_level;
    logic [EPOCH_W-1:0] r_epoch, n_epoch;
    logic               r_pend, n_pend;
    logic [AW-1:0]      r_clr, n_clr;
    logic [ORDER_W-1:0] r_code, n_code;
    logic [CW-1:0]      r_col, n_col;
    logic [RW-1:0]      r_row, n_row;
    logic [ORDER_W-1:0] r_order, n_order;
    logic [TRY_W-1:0]   r_try, n_try;
    logic [1:0]         r_dir, n_dir;
    logic [CW-1:0]      r_nc, n_nc;
    logic [RW-1:0]      r_nr, n_nr;
    t_result            r_res, n_res;
    logic               r_out_valid;
    t_result            r_out;
    logic               load_out;

    logic               vis_we;
    logic [AW-1:0]      vis_waddr, vis_raddr;
    logic [EPOCH_W-1:0] vis_wdata, vis_rdata;
    logic               stk_we;
    logic [AW-1:0]      stk_waddr, stk_raddr;
    t_frame             stk_wdata, stk_rdata;

    logic [XW-1:0]      w_x, h_x, sc_x, sr_x;
    logic [CW-1:0]      s_col;
    logic [RW-1:0]      s_row;
    logic [1:0]         dir;
    logic               in_grid;
    logic [CW-1:0]      nb_col;
    logic [RW-1:0]      nb_row;
    logic [AW-1:0]      top_addr;

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] c,
                                                input logic [RW-1:0] r);
        return AW'(AW'(r) * AW'(MAX_COLUMNS)) + AW'(c);
    endfunction

    mdc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mdc_ram #(.DEPTH(CELLS), .WIDTH(EPOCH_W)) u_visited (
        .i_clk   (i_clk),
        .i_we    (vis_we),
        .i_waddr (vis_waddr),
        .i_wdata (vis_wdata),
        .i_raddr (vis_raddr),
        .o_rdata (vis_rdata)
    );

    mdc_ram #(.DEPTH(CELLS), .WIDTH(FW)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // grid size saturated into 1..MAX, start clamped to size minus one
    always_comb begin
        if (cfg.grid_width == '0) begin
            w_x = XW'(1);
        end else if (XW'(cfg.grid_width) > XW'(MAX_COLUMNS)) begin
            w_x = XW'(MAX_COLUMNS);
        end else begin
            w_x = XW'(cfg.grid_width);
        end
        if (cfg.grid_height == '0) begin
            h_x = XW'(1);
        end else if (XW'(cfg.grid_height) > XW'(MAX_ROWS)) begin
            h_x = XW'(MAX_ROWS);
        end else begin
            h_x = XW'(cfg.grid_height);
        end
        sc_x  = (XW'(cfg.start_column) > w_x - XW'(1)) ? w_x - XW'(1)
                                                        : XW'(cfg.start_column);
        sr_x  = (XW'(cfg.start_row) > h_x - XW'(1)) ? h_x - XW'(1)
                                                     : XW'(cfg.start_row);
        s_col = sc_x[CW-1:0];
        s_row = sr_x[RW-1:0];
    end

    always_comb begin
        dir    = perm_dir(r_order, r_try[1:0]);
        nb_col = r_col;
        nb_row = r_row;
        unique case (dir)
            DIR_UP: begin
                in_grid = (r_row != '0);
                nb_row  = r_row - RW'(1);
            end
            DIR_LEFT: begin
                in_grid = (r_col != '0);
                nb_col  = r_col - CW'(1);
            end
            DIR_RIGHT: begin
                in_grid = (XW'(r_col) + XW'(1)) < w_x;
                nb_col  = r_col + CW'(1);
            end
            default: begin
                in_grid = (XW'(r_row) + XW'(1)) < h_x;
                nb_row  = r_row + RW'(1);
            end
        endcase
    end

    assign top_addr  = AW'(r_level - LW'(1));
    assign stk_raddr = top_addr;
    assign vis_raddr = cell_addr(nb_col, nb_row);

    always_comb begin
        n_state   = r_state;
        n_level   = r_level;
        n_epoch   = r_epoch;
        n_pend    = r_pend;
        n_clr     = r_clr;
        n_code    = r_code;
        n_col     = r_col;
        n_row     = r_row;
        n_order   = r_order;
        n_try     = r_try;
        n_dir     = r_dir;
        n_nc      = r_nc;
        n_nr      = r_nr;
        n_res     = r_res;
        load_out  = 1'b0;
        vis_we    = 1'b0;
        vis_waddr = cell_addr(r_nc, r_nr);
        vis_wdata = r_epoch;
        stk_we    = 1'b0;
        stk_waddr = top_addr;
        stk_wdata = '{col: r_col, row: r_row, order: r_order,
                      try_idx: r_try + TRY_W'(1)};

        unique case (r_state)
            S_CLEAR: begin
                vis_we    = 1'b1;
                vis_waddr = r_clr;
                vis_wdata = '0;
                n_clr     = r_clr + AW'(1);
                if (r_clr == AW'(CELLS - 1)) begin
                    n_pend = 1'b0;
                    if (r_pend) begin
                        n_epoch = EPOCH_W'(1);
                        n_state = S_START;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_code = clamp_code(i_order_code);
                    if (i_begin_new) begin
                        if (r_epoch == '1) begin
                            n_pend  = 1'b1;
                            n_clr   = '0;
                            n_state = S_CLEAR;
                        end else begin
                            n_epoch = r_epoch + EPOCH_W'(1);
                            n_state = S_START;
                        end
                    end else if (r_level == '0) begin
                        n_res   = '{col: '0, row: '0, side: DIR_UP,
                                    kind: EV_IDLE, fin: 1'b1};
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_TOP;
                    end
                end
            end
            S_START: begin
                vis_we    = 1'b1;
                vis_waddr = cell_addr(s_col, s_row);
                stk_we    = 1'b1;
                stk_waddr = '0;
                stk_wdata = '{col: s_col, row: s_row, order: r_code, try_idx: '0};
                n_level   = LW'(1);
                n_res     = '{col: COORD_W'(s_col), row: COORD_W'(s_row),
                              side: DIR_UP, kind: EV_START, fin: 1'b0};
                n_state   = S_EMIT;
            end
            S_TOP: begin
                n_col   = stk_rdata.col;
                n_row   = stk_rdata.row;
                n_order = stk_rdata.order;
                n_try   = stk_rdata.try_idx;
                n_state = S_PROBE;
            end
            S_PROBE: begin
                if (r_try >= TRY_W'(DIRS)) begin
                    n_level = r_level - LW'(1);
                    n_res   = '{col: COORD_W'(r_col), row: COORD_W'(r_row),
                                side: DIR_UP, kind: EV_BACK,
                                fin: (r_level == LW'(1))};
                    n_state = S_EMIT;
                end else if (!in_grid) begin
                    n_try = r_try + TRY_W'(1);
                end else begin
                    n_dir   = dir;
                    n_nc    = nb_col;
                    n_nr    = nb_row;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (vis_rdata == r_epoch) begin
                    n_try   = r_try + TRY_W'(1);
                    n_state = S_PROBE;
                end else begin
                    // mark neighbour, write back the top's next try
                    vis_we  = 1'b1;
                    stk_we  = 1'b1;
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (r_level < LW'(CELLS)) begin
                    stk_we    = 1'b1;
                    stk_waddr = AW'(r_level);
                    stk_wdata = '{col: r_nc, row: r_nr, order: r_code, try_idx: '0};
                    n_level   = r_level + LW'(1);
                end
                n_res   = '{col: COORD_W'(r_col), row: COORD_W'(r_row),
                            side: r_dir, kind: EV_CARVE, fin: 1'b0};
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_level     <= '0;
            r_epoch     <= '0;
            r_pend      <= 1'b0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_level <= n_level;
            r_epoch <= n_epoch;
            r_pend  <= n_pend;
            r_clr   <= n_clr;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_code  <= n_code;
        r_col   <= n_col;
        r_row   <= n_row;
        r_order <= n_order;
        r_try   <= n_try;
        r_dir   <= n_dir;
        r_nc    <= n_nc;
        r_nr    <= n_nr;
        r_res   <= n_res;
        if (load_out) begin
            r_out <= r_res;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_cell_column = r_out.col;
    assign o_cell_row    = r_out.row;
    assign o_wall_side   = r_out.side;
    assign o_event_kind  = r_out.kind;
    assign o_finished    = r_out.fin;

endmodule

[rtl/mdc_cfg_regs.sv]
// APB configuration register bank for the maze carver.
module mdc_cfg_regs (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [mdc_pkg::PADDR_W-1:0] paddr,
    input  logic [mdc_pkg::PDATA_W-1:0] pwdata,
    output logic [mdc_pkg::PDATA_W-1:0] prdata,
    output logic                   pready,
    output mdc_pkg::t_cfg          o_cfg
);
    import mdc_pkg::*;

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_GRID_WIDTH:   n_cfg.grid_width   = pwdata[6:0];
                REG_GRID_HEIGHT:  n_cfg.grid_height  = pwdata[6:0];
                REG_START_COLUMN: n_cfg.start_column = pwdata[5:0];
                REG_START_ROW:    n_cfg.start_row    = pwdata[5:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_GRID_WIDTH:   prdata = PDATA_W'(r_cfg.grid_width);
            REG_GRID_HEIGHT:  prdata = PDATA_W'(r_cfg.grid_height);
            REG_START_COLUMN: prdata = PDATA_W'(r_cfg.start_column);
            REG_START_ROW:    prdata = PDATA_W'(r_cfg.start_row);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{grid_width: 7'd16, grid_height: 7'd16,
                       start_column: 6'd0, start_row: 6'd0};
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[rtl/mdc_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
module mdc_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

endmodule
